// File: hdl/pscl_pkg.sv
// Package for the polar SC list decoder: sizes, fixed-point limits,
// the min-star correction table and the shared-unit control types.
// No dependencies; every hdl file imports it.
package pscl_pkg;

    localparam int CODE_LENGTH  = 64;
    localparam int LIST_MAX     = 8;
    localparam int LLR_WIDTH    = 16;
    localparam int METRIC_WIDTH = 24;

    localparam int LOG_N   = $clog2(CODE_LENGTH);
    localparam int HALF_N  = CODE_LENGTH / 2;
    localparam int HALF_W  = LOG_N - 1;
    localparam int PATH_W  = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1;
    localparam int CNT_W   = $clog2(LIST_MAX + 1);
    localparam int CAND_W  = $clog2(2 * LIST_MAX);
    localparam int CW      = $clog2(2 * LIST_MAX + 1) + 1;
    localparam int LVL_W   = (LOG_N > 1) ? $clog2(LOG_N) : 1;
    localparam int K_W     = LOG_N + 2;
    localparam int CORR_LEN = 14;
    localparam int CORR_W   = 4;
    localparam int SUM_W    = ((METRIC_WIDTH > LLR_WIDTH) ? METRIC_WIDTH : LLR_WIDTH) + 2;

    localparam logic signed [LLR_WIDTH-1:0] LLR_MAX_V = {1'b0, {(LLR_WIDTH-1){1'b1}}};
    localparam logic [METRIC_WIDTH-1:0] METRIC_MAX_V = {METRIC_WIDTH{1'b1}};

    // Shared unit operations
    typedef enum logic [1:0] {
        OP_F,
        OP_G,
        OP_PM
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    u;
        logic    exact;
    } alu_ctl_t;

    // round(16*ln(1+exp(-k/4))) on k = magnitude >> 2, zero past the table
    function automatic logic [CORR_W-1:0] corr_lut(input logic [LLR_WIDTH+1:0] m);
        logic [LLR_WIDTH-1:0] k;
        logic [CORR_W-1:0]    v;
        k = m[LLR_WIDTH+1:2];
        v = '0;
        if (k < LLR_WIDTH'(CORR_LEN)) begin
            case (k[3:0])
                4'd0:    v = 4'd11;
                4'd1:    v = 4'd9;
                4'd2:    v = 4'd8;
                4'd3:    v = 4'd6;
                4'd4:    v = 4'd5;
                4'd5:    v = 4'd4;
                4'd6:    v = 4'd3;
                4'd7:    v = 4'd3;
                4'd8:    v = 4'd2;
                4'd9:    v = 4'd2;
                default: v = 4'd1;
            endcase
        end
        return v;
    endfunction

    // clamp to +-LLR_MAX
    function automatic logic signed [LLR_WIDTH-1:0] sat_llr(input logic signed [LLR_WIDTH+1:0] v);
        logic signed [LLR_WIDTH+1:0] hi;
        hi = (LLR_WIDTH+2)'(LLR_MAX_V);
        if (v > hi) return LLR_MAX_V;
        if (v < -hi) return -LLR_MAX_V;
        return v[LLR_WIDTH-1:0];
    endfunction

endpackage

// File: hdl/pscl_alu.sv
// Shared arithmetic unit: f node (min-sum or min-star), g node and
// path metric update with saturation. Depends on pscl_pkg.
module pscl_alu import pscl_pkg::*; (
    input  alu_ctl_t                       ctl,
    input  logic signed [LLR_WIDTH-1:0]    a_in,
    input  logic signed [LLR_WIDTH-1:0]    b_in,
    input  logic [METRIC_WIDTH-1:0]        pm_in,
    output logic signed [LLR_WIDTH-1:0]    llr_out,
    output logic [METRIC_WIDTH-1:0]        pm_out
);

    logic [LLR_WIDTH-1:0]          ma, mb, mn;
    logic signed [LLR_WIDTH+1:0]   sum_ab, dif_ab, f_base, f_raw, g_raw;
    logic [LLR_WIDTH+1:0]          msum, mdif;
    logic                          both_fin, a_pos;
    logic [SUM_W-1:0]              pen, pm_sum;

    // magnitudes and sums
    always_comb begin
        ma = LLR_WIDTH'(a_in[LLR_WIDTH-1] ? -a_in : a_in);
        mb = LLR_WIDTH'(b_in[LLR_WIDTH-1] ? -b_in : b_in);
        mn = (ma < mb) ? ma : mb;
        sum_ab = (LLR_WIDTH+2)'(a_in) + (LLR_WIDTH+2)'(b_in);
        dif_ab = (LLR_WIDTH+2)'(a_in) - (LLR_WIDTH+2)'(b_in);
        msum = sum_ab[LLR_WIDTH+1] ? -sum_ab : sum_ab;
        mdif = dif_ab[LLR_WIDTH+1] ? -dif_ab : dif_ab;
        both_fin = (ma < LLR_MAX_V) && (mb < LLR_MAX_V);
    end

    // f and g nodes
    always_comb begin
        f_base = $signed({2'b00, mn});
        if (a_in == '0 || b_in == '0) begin
            f_raw = '0;
        end else if (a_in[LLR_WIDTH-1] != b_in[LLR_WIDTH-1]) begin
            f_raw = -f_base;
        end else begin
            f_raw = f_base;
        end
        if (ctl.exact && both_fin) begin
            f_raw = f_raw + $signed({{(LLR_WIDTH-2){1'b0}}, corr_lut(msum)})
                          - $signed({{(LLR_WIDTH-2){1'b0}}, corr_lut(mdif)});
        end
        g_raw = ctl.u ? -dif_ab : sum_ab;
        llr_out = sat_llr((ctl.op == OP_G) ? g_raw : f_raw);
    end

    // metric: penalty when the hard decision disagrees with u, plus the correction in exact mode
    always_comb begin
        a_pos = !a_in[LLR_WIDTH-1] && (a_in != '0);
        pen = (a_pos == ctl.u) ? SUM_W'(ma) : '0;
        if (ctl.exact && (ma < LLR_MAX_V)) begin
            pen = pen + SUM_W'(corr_lut({2'b00, ma}));
        end
        pm_sum = SUM_W'(pm_in) + pen;
        if (ctl.op != OP_PM) begin
            pm_out = pm_in;
        end else if (pm_sum > SUM_W'(METRIC_MAX_V)) begin
            pm_out = METRIC_MAX_V;
        end else begin
            pm_out = pm_sum[METRIC_WIDTH-1:0];
        end
    end

endmodule

// File: hdl/polar_scl_decoder.sv
// Polar successive-cancellation list decoder top level: frame buffer,
// per-path LLR and partial-sum memories, and the decode sequencer.
// Depends on pscl_pkg and pscl_alu.
//
// A frame is CODE_LENGTH words, loaded one per cycle while s_valid is high;
// s_ready then drops while the frame decodes and the information bits of the
// best path come out, one word per information position, before the next
// frame is taken. Every node update goes through the single shared unit as a
// read, then a compute and write back, for each active path at every bit
// position, and each decided bit is then folded into the partial sums. At every
// information bit each surviving path is copied into the other bank through
// one memory port, and when the candidates outnumber the list size the list is
// sorted by a serial min scan over all candidates, repeated once per survivor.
// On output each position is read and checked in turn, and each information
// position waits for m_ready.
module polar_scl_decoder import pscl_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [LLR_WIDTH-1:0] s_channel_llr,
    input  logic                        s_is_info,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_decoded_bit,
    output logic                        m_last_bit,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [3:0]                  cfg_data
);

    localparam logic CFG_LIST_SIZE = 1'b0;
    localparam logic CFG_APPROX    = 1'b1;

    typedef enum logic [4:0] {
        ST_LOAD, ST_POS, ST_POSF, ST_LVL, ST_NRD, ST_NEX, ST_FZ, ST_CAND,
        ST_SEL, ST_CPYR, ST_CPY, ST_PINIT, ST_PLVL, ST_PCOPY, ST_PRD, ST_PEX,
        ST_PRET, ST_NEXT, ST_BEST, ST_ORD, ST_OCHK, ST_OUT
    } state_t;

    localparam int LLR_AW = 1 + PATH_W + LOG_N;
    localparam int SUM_AW = 2 + PATH_W + LOG_N;

    state_t st_reg;

    // configuration
    logic [3:0] list_size_reg;
    logic       approx_reg;

    // control
    logic [LOG_N-1:0]  cnt_reg, last_info_reg, i_reg;
    logic              flag_reg, bank_reg, sel_reg, bv_reg, ctx_reg;
    logic [PATH_W-1:0] p_reg, r_reg, par_reg, pp_reg, best_reg;
    logic [LVL_W-1:0]  s_reg;
    logic [HALF_W-1:0] j_reg;
    logic [CNT_W-1:0]  act_reg, keep_reg;
    logic [CAND_W-1:0] c_reg, bi_reg;
    logic [K_W-1:0]    k_reg;
    logic              pb_reg, pu_reg, bit_reg;
    logic              m_valid_reg, m_bit_reg, m_last_reg;

    // payload
    logic [METRIC_WIDTH-1:0]      pm_reg   [LIST_MAX];
    logic signed [LLR_WIDTH-1:0]  leaf_reg [LIST_MAX];
    logic [METRIC_WIDTH-1:0]      cm_reg   [2*LIST_MAX];
    logic [CAND_W-1:0]            order_reg[LIST_MAX];
    logic [2*LIST_MAX-1:0]        used_reg;
    logic [METRIC_WIDTH-1:0]      bm_reg;
    logic [HALF_N-1:0]            cur_reg;
    logic [HALF_N-1:0]            cur_next;

    // memories
    logic [LLR_WIDTH:0]          ch_mem  [CODE_LENGTH];
    logic signed [LLR_WIDTH-1:0] llr_mem [2**LLR_AW];
    logic                        sum_mem [2**SUM_AW];
    logic [LLR_WIDTH:0]          ch_rda_reg, ch_rdb_reg;
    logic signed [LLR_WIDTH-1:0] llr_rda_reg, llr_rdb_reg;
    logic                        sum_rd_reg;

    logic                        ch_we, llr_we, sum_we;
    logic [LLR_WIDTH:0]          ch_wdata;
    logic [LOG_N-1:0]            ch_ra, ch_rb;
    logic [LLR_AW-1:0]           llr_ra, llr_rb, llr_wa;
    logic signed [LLR_WIDTH-1:0] llr_wdata;
    logic [SUM_AW-1:0]           sum_ra, sum_wa;
    logic                        sum_wdata;

    // derived indexes
    logic [LOG_N-1:0]  lsize, j_ext, node_lo, node_a, node_b;
    logic              top_lvl, j_last, right, p_last, r_last;
    logic [CW-1:0]     c_x, act_x, cnt_x, lim_x, cc_x, keep_x;
    logic [CAND_W-1:0] cc;
    logic              c_bit, cc_bit, c_last, take;
    logic [PATH_W-1:0] c_par, cc_par, pm_ridx;
    logic [CAND_W-1:0] cm_ridx, nb;
    logic [METRIC_WIDTH-1:0]     pm_rd, cm_rd;
    logic signed [LLR_WIDTH-1:0] leaf_rd, in_llr;
    logic [K_W-1:0]    kd;
    logic              b_take;

    alu_ctl_t                    alu_ctl;
    logic signed [LLR_WIDTH-1:0] alu_a, alu_b, alu_llr;
    logic [METRIC_WIDTH-1:0]     alu_pm;

    pscl_alu u_alu (
        .ctl     (alu_ctl),
        .a_in    (alu_a),
        .b_in    (alu_b),
        .pm_in   (pm_rd),
        .llr_out (alu_llr),
        .pm_out  (alu_pm)
    );

    // tree and list indexing
    always_comb begin
        lsize   = LOG_N'(1) << s_reg;
        j_ext   = LOG_N'(j_reg);
        node_lo = lsize + j_ext;
        node_a  = (lsize << 1) + j_ext;
        node_b  = node_a + lsize;
        top_lvl = (s_reg == LVL_W'(LOG_N - 1));
        j_last  = (j_ext == lsize - 1'b1);
        right   = i_reg[s_reg];
        p_last  = (CNT_W'(p_reg) == act_reg - 1'b1);
        r_last  = (CNT_W'(r_reg) == keep_reg - 1'b1);

        c_x   = CW'(c_reg);
        act_x = CW'(act_reg);
        cnt_x = act_x << 1;
        if (list_size_reg == 4'd0) begin
            lim_x = CW'(1);
        end else if (int'(list_size_reg) > LIST_MAX) begin
            lim_x = CW'(LIST_MAX);
        end else begin
            lim_x = CW'(list_size_reg);
        end
        keep_x = (cnt_x > lim_x) ? lim_x : cnt_x;
        c_bit  = (c_x >= act_x);
        c_par  = PATH_W'(c_bit ? c_x - act_x : c_x);
        c_last = (c_x == cnt_x - 1'b1);

        cc     = sel_reg ? order_reg[r_reg] : CAND_W'(r_reg);
        cc_x   = CW'(cc);
        cc_bit = (cc_x >= act_x);
        cc_par = PATH_W'(cc_bit ? cc_x - act_x : cc_x);

        case (st_reg)
            ST_CAND: pm_ridx = c_par;
            default: pm_ridx = p_reg;
        endcase
        pm_rd   = pm_reg[pm_ridx];
        leaf_rd = leaf_reg[pm_ridx];

        case (st_reg)
            ST_CPYR: cm_ridx = cc;
            default: cm_ridx = c_reg;
        endcase
        cm_rd = cm_reg[cm_ridx];

        take   = !used_reg[c_reg] && (!bv_reg || cm_rd < bm_reg);
        nb     = take ? c_reg : bi_reg;
        b_take = !bv_reg || pm_rd < bm_reg;
        kd     = k_reg - 1'b1;

        // partial-sum fold step: right copy, left xor with the sibling sum
        cur_next = cur_reg;
        cur_next[node_lo[HALF_W-1:0]] = cur_reg[j_reg];
        cur_next[j_reg] = cur_reg[j_reg] ^ sum_rd_reg;

        in_llr = (s_channel_llr == {1'b1, {(LLR_WIDTH-1){1'b0}}}) ? -LLR_MAX_V
                                                                  : s_channel_llr;
    end

    // shared unit operands
    always_comb begin
        alu_ctl.exact = !approx_reg;
        alu_ctl.u     = sum_rd_reg;
        alu_ctl.op    = right ? OP_G : OP_F;
        alu_a = top_lvl ? ch_rda_reg[LLR_WIDTH-1:0] : llr_rda_reg;
        alu_b = top_lvl ? ch_rdb_reg[LLR_WIDTH-1:0] : llr_rdb_reg;
        if (st_reg == ST_FZ || st_reg == ST_CAND) begin
            alu_ctl.op = OP_PM;
            alu_ctl.u  = (st_reg == ST_CAND) ? c_bit : 1'b0;
            alu_a      = leaf_rd;
            alu_b      = leaf_rd;
        end
    end

    // memory ports
    always_comb begin
        ch_we    = (st_reg == ST_LOAD) && s_valid;
        ch_wdata = {s_is_info, in_llr};
        ch_ra    = (st_reg == ST_NRD) ? j_ext : i_reg;
        ch_rb    = j_ext + lsize;

        llr_ra = (st_reg == ST_CPY) ? {bank_reg, par_reg, k_reg[LOG_N-1:0]}
                                    : {bank_reg, p_reg, node_a};
        llr_rb = {bank_reg, p_reg, node_b};
        if (st_reg == ST_CPY) begin
            llr_we    = (k_reg != '0) && (kd < K_W'(CODE_LENGTH));
            llr_wa    = {~bank_reg, r_reg, kd[LOG_N-1:0]};
            llr_wdata = llr_rda_reg;
        end else begin
            llr_we    = (st_reg == ST_NEX);
            llr_wa    = {bank_reg, p_reg, node_lo};
            llr_wdata = alu_llr;
        end

        case (st_reg)
            ST_PRD:  sum_ra = {pb_reg, pp_reg, 1'b1, node_lo};
            ST_CPY:  sum_ra = {bank_reg, par_reg, k_reg[LOG_N:0]};
            ST_ORD:  sum_ra = {bank_reg, best_reg, 1'b0, i_reg};
            default: sum_ra = {bank_reg, p_reg, 1'b1, node_lo};
        endcase
        case (st_reg)
            ST_PINIT: begin
                sum_we    = 1'b1;
                sum_wa    = {pb_reg, pp_reg, 1'b0, i_reg};
                sum_wdata = pu_reg;
            end
            ST_PCOPY: begin
                sum_we    = 1'b1;
                sum_wa    = {pb_reg, pp_reg, 1'b1, node_lo};
                sum_wdata = cur_reg[j_reg];
            end
            ST_CPY: begin
                sum_we    = (k_reg != '0);
                sum_wa    = {~bank_reg, r_reg, kd[LOG_N:0]};
                sum_wdata = sum_rd_reg;
            end
            default: begin
                sum_we    = 1'b0;
                sum_wa    = {pb_reg, pp_reg, 1'b0, i_reg};
                sum_wdata = pu_reg;
            end
        endcase
    end

    // frame buffer: flag and channel LLR per position
    always_ff @(posedge aclk) begin
        if (ch_we) begin
            ch_mem[cnt_reg] <= ch_wdata;
        end
        ch_rda_reg <= ch_mem[ch_ra];
        ch_rdb_reg <= ch_mem[ch_rb];
    end

    // node LLRs, two banks of paths
    always_ff @(posedge aclk) begin
        if (llr_we) begin
            llr_mem[llr_wa] <= llr_wdata;
        end
        llr_rda_reg <= llr_mem[llr_ra];
        llr_rdb_reg <= llr_mem[llr_rb];
    end

    // decided bits and left partial sums, two banks of paths
    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_wa] <= sum_wdata;
        end
        sum_rd_reg <= sum_mem[sum_ra];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_size_reg <= 4'd8;
            approx_reg    <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LIST_SIZE: list_size_reg <= cfg_data;
                CFG_APPROX:    approx_reg    <= cfg_data[0];
                default:       approx_reg    <= approx_reg;
            endcase
        end
    end

    // decode sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_LOAD;
            cnt_reg     <= '0;
            bank_reg    <= 1'b0;
            act_reg     <= CNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            case (st_reg)
                ST_LOAD: begin
                    if (s_valid) begin
                        if (s_is_info) last_info_reg <= cnt_reg;
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == LOG_N'(CODE_LENGTH - 1)) begin
                            act_reg   <= CNT_W'(1);
                            pm_reg[0] <= '0;
                            i_reg     <= '0;
                            st_reg    <= ST_POS;
                        end
                    end
                end
                ST_POS: st_reg <= ST_POSF;
                ST_POSF: begin
                    flag_reg <= ch_rda_reg[LLR_WIDTH];
                    p_reg    <= '0;
                    s_reg    <= LVL_W'(LOG_N - 1);
                    st_reg   <= ST_LVL;
                end
                ST_LVL: begin
                    j_reg <= '0;
                    if ((i_reg & (lsize - 1'b1)) != '0) begin
                        s_reg <= s_reg - 1'b1;
                    end else begin
                        st_reg <= ST_NRD;
                    end
                end
                ST_NRD: st_reg <= ST_NEX;
                ST_NEX: begin
                    if (s_reg == '0) leaf_reg[p_reg] <= alu_llr;
                    if (!j_last) begin
                        j_reg  <= j_reg + 1'b1;
                        st_reg <= ST_NRD;
                    end else if (s_reg != '0) begin
                        s_reg  <= s_reg - 1'b1;
                        st_reg <= ST_LVL;
                    end else if (!p_last) begin
                        p_reg  <= p_reg + 1'b1;
                        s_reg  <= LVL_W'(LOG_N - 1);
                        st_reg <= ST_LVL;
                    end else begin
                        p_reg  <= '0;
                        c_reg  <= '0;
                        st_reg <= flag_reg ? ST_CAND : ST_FZ;
                    end
                end
                // frozen bit: metric update, then push u=0 in place
                ST_FZ: begin
                    pm_reg[p_reg] <= alu_pm;
                    pp_reg  <= p_reg;
                    pb_reg  <= bank_reg;
                    pu_reg  <= 1'b0;
                    ctx_reg <= 1'b0;
                    st_reg  <= ST_PINIT;
                end
                // candidate metrics: 0 children then 1 children
                ST_CAND: begin
                    cm_reg[c_reg]   <= alu_pm;
                    used_reg[c_reg] <= 1'b0;
                    if (!c_last) begin
                        c_reg <= c_reg + 1'b1;
                    end else begin
                        keep_reg <= CNT_W'(keep_x);
                        sel_reg  <= (cnt_x > lim_x);
                        c_reg    <= '0;
                        r_reg    <= '0;
                        bv_reg   <= 1'b0;
                        st_reg   <= (cnt_x > lim_x) ? ST_SEL : ST_CPYR;
                    end
                end
                // serial min scan, strict compare keeps the lower index
                ST_SEL: begin
                    if (take) begin
                        bm_reg <= cm_rd;
                    end
                    bi_reg <= nb;
                    if (!c_last) begin
                        bv_reg <= bv_reg || take;
                        c_reg  <= c_reg + 1'b1;
                    end else begin
                        order_reg[r_reg] <= nb;
                        used_reg[nb]     <= 1'b1;
                        bv_reg <= 1'b0;
                        c_reg  <= '0;
                        if (r_last) begin
                            r_reg  <= '0;
                            st_reg <= ST_CPYR;
                        end else begin
                            r_reg <= r_reg + 1'b1;
                        end
                    end
                end
                ST_CPYR: begin
                    pm_reg[r_reg] <= cm_rd;
                    par_reg <= cc_par;
                    bit_reg <= cc_bit;
                    k_reg   <= '0;
                    st_reg  <= ST_CPY;
                end
                // stream parent state into the other bank
                ST_CPY: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == K_W'(2 * CODE_LENGTH)) begin
                        pp_reg  <= r_reg;
                        pb_reg  <= ~bank_reg;
                        pu_reg  <= bit_reg;
                        ctx_reg <= 1'b1;
                        st_reg  <= ST_PINIT;
                    end
                end
                // partial-sum update for one path
                ST_PINIT: begin
                    cur_reg <= HALF_N'(pu_reg);
                    s_reg   <= '0;
                    st_reg  <= ST_PLVL;
                end
                ST_PLVL: begin
                    j_reg <= '0;
                    if (!right) begin
                        st_reg <= ST_PCOPY;
                    end else if (top_lvl) begin
                        st_reg <= ST_PRET;
                    end else begin
                        st_reg <= ST_PRD;
                    end
                end
                ST_PCOPY: begin
                    if (j_last) begin
                        st_reg <= ST_PRET;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_PRD: st_reg <= ST_PEX;
                ST_PEX: begin
                    cur_reg <= cur_next;
                    if (j_last) begin
                        s_reg  <= s_reg + 1'b1;
                        st_reg <= ST_PLVL;
                    end else begin
                        j_reg  <= j_reg + 1'b1;
                        st_reg <= ST_PRD;
                    end
                end
                ST_PRET: begin
                    if (ctx_reg) begin
                        if (r_last) begin
                            bank_reg <= ~bank_reg;
                            act_reg  <= keep_reg;
                            st_reg   <= ST_NEXT;
                        end else begin
                            r_reg  <= r_reg + 1'b1;
                            st_reg <= ST_CPYR;
                        end
                    end else if (p_last) begin
                        st_reg <= ST_NEXT;
                    end else begin
                        p_reg  <= p_reg + 1'b1;
                        st_reg <= ST_FZ;
                    end
                end
                ST_NEXT: begin
                    if (i_reg == LOG_N'(CODE_LENGTH - 1)) begin
                        p_reg  <= '0;
                        bv_reg <= 1'b0;
                        st_reg <= ST_BEST;
                    end else begin
                        i_reg  <= i_reg + 1'b1;
                        st_reg <= ST_POS;
                    end
                end
                // lowest metric, ties to the lowest rank
                ST_BEST: begin
                    if (b_take) begin
                        bm_reg   <= pm_rd;
                        best_reg <= p_reg;
                    end
                    bv_reg <= 1'b1;
                    if (p_last) begin
                        i_reg  <= '0;
                        st_reg <= ST_ORD;
                    end else begin
                        p_reg <= p_reg + 1'b1;
                    end
                end
                ST_ORD: st_reg <= ST_OCHK;
                ST_OCHK: begin
                    if (ch_rda_reg[LLR_WIDTH]) begin
                        m_valid_reg <= 1'b1;
                        m_bit_reg   <= sum_rd_reg;
                        m_last_reg  <= (i_reg == last_info_reg);
                        st_reg      <= ST_OUT;
                    end else if (i_reg == LOG_N'(CODE_LENGTH - 1)) begin
                        st_reg <= ST_LOAD;
                    end else begin
                        i_reg  <= i_reg + 1'b1;
                        st_reg <= ST_ORD;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (i_reg == LOG_N'(CODE_LENGTH - 1)) begin
                            st_reg <= ST_LOAD;
                        end else begin
                            i_reg  <= i_reg + 1'b1;
                            st_reg <= ST_ORD;
                        end
                    end
                end
                default: st_reg <= ST_LOAD;
            endcase
        end
    end

    assign s_ready       = (st_reg == ST_LOAD);
    assign m_valid       = m_valid_reg;
    assign m_decoded_bit = m_bit_reg;
    assign m_last_bit    = m_last_reg;

    // no new frame is taken while results are pending
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready)
        else $error("input open while a result word is pending");

    // list occupancy stays within 1..LIST_MAX
    assert property (@(posedge aclk) disable iff (!aresetn)
        (act_reg != '0) && (int'(act_reg) <= LIST_MAX))
        else $error("active path count out of range");

    // the word that completes a frame starts the decode
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && cnt_reg == LOG_N'(CODE_LENGTH - 1)) |=> !s_ready)
        else $error("decode did not start after a full frame");

    // the last information bit closes the frame output
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_bit) |=> !m_valid)
        else $error("result word after the last bit of a frame");

endmodule

// File: verif/polar_scl_decoder_tb.sv
// Self-checking testbench for polar_scl_decoder: loads frames of channel
// words, predicts the decoded information bits per frame and checks the output.
// Depends on pscl_pkg and the RTL of polar_scl_decoder.
`timescale 1ns / 100ps

module polar_scl_decoder_tb;
    import pscl_pkg::*;

    localparam int FRAMES    = 7;
    localparam int LLR_LIM   = 32767;
    localparam int MET_LIM   = (1 << METRIC_WIDTH) - 1;
    localparam int DRAIN_CYC = 120000;

    localparam logic REG_LIST_SIZE = 1'b0;
    localparam logic REG_APPROX    = 1'b1;

    typedef enum int {INFO_RANDOM, INFO_NONE, INFO_ALL} info_mix_t;

    typedef struct {
        logic signed [LLR_WIDTH-1:0] llr;
        logic                        info;
    } chan_word_t;

    typedef struct {
        logic dec;
        logic last;
    } out_word_t;

    typedef struct {
        logic [3:0] list_size;
        logic       approx;
        info_mix_t  mix;
        bit         no_gaps;
    } frame_plan_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [LLR_WIDTH-1:0] s_channel_llr = '0;
    logic s_is_info = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_decoded_bit;
    logic m_last_bit;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = 1'b0;
    logic [3:0] cfg_data = '0;

    polar_scl_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_channel_llr(s_channel_llr), .s_is_info(s_is_info),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_decoded_bit(m_decoded_bit), .m_last_bit(m_last_bit),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------- decoder predictor ----------------
    int          chan_llr [CODE_LENGTH];
    bit          chan_info[CODE_LENGTH];
    int          node_llr [LIST_MAX][CODE_LENGTH];
    bit          psum     [LIST_MAX][2*CODE_LENGTH];
    int unsigned metric   [LIST_MAX];
    int          n_paths;
    int          words_in;
    int unsigned cur_list = 8;
    bit          cur_approx = 1'b1;
    out_word_t   want_bits[$];
    int          errors = 0;

    function automatic int clamp_llr(int v);
        if (v > LLR_LIM) return LLR_LIM;
        if (v < -LLR_LIM) return -LLR_LIM;
        return v;
    endfunction

    function automatic int absv(int v);
        return v < 0 ? -v : v;
    endfunction

    // log(1+e^-x) correction, indexed by magnitude/4
    function automatic int corr_term(int d);
        int k;
        k = absv(d) >> 2;
        case (k)
            0: return 11;  1: return 9;  2: return 8;  3: return 6;
            4: return 5;   5: return 4;  6: return 3;  7: return 3;
            8: return 2;   9: return 2;  10, 11, 12, 13: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic int check_node(int a, int b);
        int ma, mb, m, r;
        ma = absv(a);
        mb = absv(b);
        m = ma < mb ? ma : mb;
        if (a == 0 || b == 0) r = 0;
        else r = ((a < 0) != (b < 0)) ? -m : m;
        if (!cur_approx && ma < LLR_LIM && mb < LLR_LIM)
            r += corr_term(a + b) - corr_term(a - b);
        return clamp_llr(r);
    endfunction

    function automatic int unsigned metric_add(int unsigned pm, int l, bit u);
        longint unsigned pen, sum;
        pen = 0;
        if ((l > 0) == u) pen = absv(l);
        if (!cur_approx && absv(l) < LLR_LIM) pen += corr_term(l);
        sum = pm + pen;
        return sum > MET_LIM ? MET_LIM : int'(sum);
    endfunction

    function automatic void descend(int p, int i);
        int size, a, b;
        bit right;
        for (int s = LOG_N - 1; s >= 0; s--) begin
            size = 1 << s;
            right = (i >> s) & 1;
            if ((i & (size - 1)) == 0) begin
                for (int j = 0; j < size; j++) begin
                    if (s == LOG_N - 1) begin
                        a = chan_llr[j];
                        b = chan_llr[j + size];
                    end else begin
                        a = node_llr[p][2*size + j];
                        b = node_llr[p][3*size + j];
                    end
                    if (right)
                        node_llr[p][size + j] = clamp_llr(psum[p][CODE_LENGTH + size + j]
                                                          ? b - a : a + b);
                    else
                        node_llr[p][size + j] = check_node(a, b);
                end
            end
        end
    endfunction

    // fold the decided bit back up into left-sibling partial sums
    function automatic void fold_bit(int p, int i, bit u);
        bit cur[CODE_LENGTH];
        int size;
        cur[0] = u;
        psum[p][i] = u;
        for (int s = 0; s < LOG_N; s++) begin
            size = 1 << s;
            if (((i >> s) & 1) == 0) begin
                for (int j = 0; j < size; j++) psum[p][CODE_LENGTH + size + j] = cur[j];
                return;
            end
            for (int j = 0; j < size; j++) begin
                cur[size + j] = cur[j];
                cur[j] = cur[j] ^ psum[p][CODE_LENGTH + size + j];
            end
        end
    endfunction

    function automatic void decode_frame();
        int          leaf[LIST_MAX];
        int unsigned cm[2*LIST_MAX];
        int          pick[2*LIST_MAX];
        bit          taken[2*LIST_MAX];
        int          saved_llr[LIST_MAX][CODE_LENGTH];
        bit          saved_sum[LIST_MAX][2*CODE_LENGTH];
        int          lim, cnt, keep, bi, par, best, last_k;
        out_word_t   w;
        lim = cur_list == 0 ? 1 : (cur_list > LIST_MAX ? LIST_MAX : cur_list);
        n_paths = 1;
        metric[0] = 0;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            for (int p = 0; p < n_paths; p++) begin
                descend(p, i);
                leaf[p] = node_llr[p][1];
            end
            if (!chan_info[i]) begin
                for (int p = 0; p < n_paths; p++) begin
                    metric[p] = metric_add(metric[p], leaf[p], 1'b0);
                    fold_bit(p, i, 1'b0);
                end
            end else begin
                cnt = 2 * n_paths;
                for (int c = 0; c < cnt; c++) begin
                    par = c < n_paths ? c : c - n_paths;
                    cm[c] = metric_add(metric[par], leaf[par], c >= n_paths);
                    pick[c] = c;
                    taken[c] = 0;
                end
                keep = cnt <= lim ? cnt : lim;
                // serial min search, ties to lower candidate
                if (cnt > lim) begin
                    for (int r = 0; r < keep; r++) begin
                        bi = cnt;
                        for (int c = 0; c < cnt; c++)
                            if (!taken[c] && (bi == cnt || cm[c] < cm[bi])) bi = c;
                        pick[r] = bi;
                        taken[bi] = 1;
                    end
                end
                saved_llr = node_llr;
                saved_sum = psum;
                for (int r = 0; r < keep; r++) begin
                    par = pick[r] < n_paths ? pick[r] : pick[r] - n_paths;
                    node_llr[r] = saved_llr[par];
                    psum[r] = saved_sum[par];
                    metric[r] = cm[pick[r]];
                    fold_bit(r, i, pick[r] >= n_paths);
                end
                n_paths = keep;
            end
        end
        best = 0;
        for (int p = 1; p < n_paths; p++)
            if (metric[p] < metric[best]) best = p;
        last_k = -1;
        for (int i = 0; i < CODE_LENGTH; i++)
            if (chan_info[i]) last_k = i;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            if (chan_info[i]) begin
                w.dec = psum[best][i];
                w.last = (i == last_k);
                want_bits.push_back(w);
            end
        end
    endfunction

    function automatic void take_word(logic signed [LLR_WIDTH-1:0] v, logic inf);
        chan_llr[words_in] = clamp_llr(int'(v));
        chan_info[words_in] = inf;
        words_in++;
        if (words_in == CODE_LENGTH) begin
            words_in = 0;
            decode_frame();
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, exp_v);
        errors++;
    endtask

    // ---------------- result side ----------------
    bit rx_gaps = 1'b1;
    bit hold_done = 1'b0;
    int hold_left = 0;
    logic mv_q, mr_q, md_q, ml_q;

    always @(negedge aclk) begin
        mv_q <= m_valid;
        mr_q <= m_ready;
        md_q <= m_decoded_bit;
        ml_q <= m_last_bit;
    end

    // ready driver, with one long hold-off while results are pending
    always @(posedge aclk) begin
        if (!hold_done && mv_q) begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(rx_gaps && $urandom_range(99) < 9);
        end
    end

    always @(posedge aclk) begin
        out_word_t w;
        if (aresetn && mv_q && mr_q) begin
            if (want_bits.size() == 0) begin
                report_mismatch("unexpected word", md_q, -1);
            end else begin
                w = want_bits.pop_front();
                if (md_q !== w.dec) report_mismatch("decoded_bit", md_q, w.dec);
                if (ml_q !== w.last) report_mismatch("last_bit", ml_q, w.last);
            end
        end
    end

    // ---------------- stimulus ----------------
    chan_word_t head_rows[24] = '{
        '{16'sd32767, 1'b1}, '{-16'sd32767, 1'b0}, '{-16'sd32768, 1'b1}, '{16'sd0, 1'b1},
        '{16'sd1, 1'b0}, '{-16'sd1, 1'b1}, '{16'sd32766, 1'b1}, '{-16'sd32766, 1'b0},
        '{16'sd55, 1'b1}, '{16'sd56, 1'b1}, '{-16'sd55, 1'b1}, '{-16'sd56, 1'b0},
        '{16'sd3, 1'b1}, '{16'sd4, 1'b0}, '{16'sd16, 1'b1}, '{-16'sd16, 1'b1},
        '{16'sh5555, 1'b0}, '{16'shAAAA, 1'b1}, '{16'sd0, 1'b0}, '{16'sd32767, 1'b0},
        '{-16'sd32768, 1'b0}, '{16'sd200, 1'b1}, '{-16'sd200, 1'b0}, '{16'sd7, 1'b1}
    };

    // second frame keeps the reset setup so it is offered during the hold-off
    frame_plan_t plan[FRAMES] = '{
        '{4'd8,  1'b1, INFO_RANDOM, 1'b0},
        '{4'd8,  1'b1, INFO_RANDOM, 1'b0},
        '{4'd15, 1'b0, INFO_NONE,   1'b0},
        '{4'd0,  1'b1, INFO_ALL,    1'b1},
        '{4'd8,  1'b0, INFO_RANDOM, 1'b0},
        '{4'd4,  1'b0, INFO_RANDOM, 1'b1},
        '{4'd2,  1'b1, INFO_RANDOM, 1'b0}
    };

    bit tx_gaps = 1'b1;

    task automatic write_reg(input logic idx, input logic [3:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        if (idx == REG_LIST_SIZE) cur_list = val;
        else cur_approx = val[0];
    endtask

    task automatic send_word(input logic signed [LLR_WIDTH-1:0] v, input logic inf);
        logic rdy;
        if (tx_gaps && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_channel_llr <= v;
        s_is_info <= inf;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        take_word(v, inf);
    endtask

    function automatic logic signed [LLR_WIDTH-1:0] rand_llr();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return LLR_WIDTH'(int'($urandom_range(1600)) - 800);
        if (pick < 85) return LLR_WIDTH'($urandom);
        if (pick < 92) return LLR_WIDTH'(int'($urandom_range(120)) - 60);
        case ($urandom_range(2))
            0: return 16'sd32767;
            1: return -16'sd32767;
            default: return -16'sd32768;
        endcase
    endfunction

    initial begin
        logic signed [LLR_WIDTH-1:0] v;
        logic inf;
        int   guard;
        bit   prev_empty;
        words_in = 0;
        n_paths = 1;
        prev_empty = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int f = 0; f < FRAMES; f++) begin
            if (f == FRAMES - 1) begin
                plan[f].list_size = 4'($urandom_range(1, 8));
                plan[f].approx = 1'($urandom_range(1));
            end
            // settle before touching registers
            if (f > 0 && (plan[f].list_size != plan[f-1].list_size ||
                          plan[f].approx != plan[f-1].approx)) begin
                s_valid <= 1'b0;
                while (want_bits.size() != 0) @(posedge aclk);
                if (prev_empty) repeat (DRAIN_CYC) @(posedge aclk);
                write_reg(REG_LIST_SIZE, plan[f].list_size);
                write_reg(REG_APPROX, {3'b0, plan[f].approx});
                cfg_wr_en <= 1'b0;
            end
            tx_gaps = !plan[f].no_gaps;
            rx_gaps = !plan[f].no_gaps;
            prev_empty = (plan[f].mix == INFO_NONE);
            for (int i = 0; i < CODE_LENGTH; i++) begin
                if (f == 0 && i < 24) begin
                    v = head_rows[i].llr;
                    inf = head_rows[i].info;
                end else begin
                    v = rand_llr();
                    case (plan[f].mix)
                        INFO_NONE: inf = 1'b0;
                        INFO_ALL:  inf = 1'b1;
                        default:   inf = ($urandom_range(99) < 45);
                    endcase
                end
                send_word(v, inf);
            end
        end
        s_valid <= 1'b0;
        guard = 0;
        while (want_bits.size() != 0 && guard < 400000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (2000) @(posedge aclk);
        if (errors == 0 && want_bits.size() == 0) begin
            $display("end of test: clean");
        end else begin
            if (want_bits.size() != 0)
                report_mismatch("words never received", 0, want_bits.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
